FILE: src/bfba_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the best-fit block allocator.
// No dependencies.
package bfba_pkg;

    localparam int ADDR_W       = 16;
    localparam int LEN_W        = 17;
    localparam int MERGE_RATIO  = 3;
    localparam int RETRY_BUDGET = 2;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_MERGE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_MEM  = 2'd1,
        STAT_UNKNOWN = 2'd2,
        STAT_OUTSIDE = 2'd3
    } status_t;

    typedef struct packed {
        logic              used;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
    } entry_t;

endpackage

FILE: src/best_fit_block_allocator.sv
`timescale 1ns / 1ps
// Best-fit block allocator: header table in a single-port-read memory, walked by one sequencer.
// Depends on bfba_pkg.
//
// One command at a time. Each walk of the header table reads one entry at a time (registered
// read, then compare); free and query take one lookup walk plus one statistics walk. Allocate
// adds a best-fit walk. A merge pass restarts its pairwise search after every absorption and
// ends with two more walks, and allocate runs up to three of them. Every walk goes through the
// table memory's single read port.
module best_fit_block_allocator #(
    parameter int MEM_BYTES    = 65536,
    parameter int MAX_ENTRIES  = 256,
    parameter int HEADER_BYTES = 12,
    parameter int SPLIT_SLACK  = 4,
    parameter int ALIGN_SHIFT  = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic        has_block,
    input  logic [15:0] block_base,
    input  logic [16:0] request_size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] result_base,
    output logic [16:0] result_len,
    output logic [15:0] copy_src,
    output logic [16:0] copy_len,
    output logic [15:0] zero_start,
    output logic [16:0] zero_len,
    output logic [16:0] largest_free,
    output logic [16:0] total_free
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = 20;
    localparam logic [17:0] AMASK = 18'((1 << ALIGN_SHIFT) - 1);
    localparam logic signed [SW-1:0] MEM_S = SW'(MEM_BYTES);
    localparam logic signed [SW-1:0] HDR_S = SW'(HEADER_BYTES);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_TRY,
        S_FD_RD, S_FD_CHK, S_FD_DONE, S_Z,
        S_FT_RD, S_FT_CHK, S_FT_DONE, S_GRANT, S_REL,
        S_MG_START, S_MI_RD, S_MI_LD, S_MJ_RD, S_MJ_CHK, S_MG_WR_I,
        S_TP_RD, S_TP_CHK, S_CP_RD, S_CP_CHK, S_MG_END,
        S_ST_INIT, S_ST_RD, S_ST_CHK, S_OUT
    } state_t;

    bfba_pkg::entry_t mem [MAX_ENTRIES];
    bfba_pkg::entry_t rd_q;
    logic             mem_we;
    logic [IW-1:0]    mem_wa;
    logic [IW-1:0]    mem_ra;
    bfba_pkg::entry_t mem_wd;

    state_t         state_reg, state_next;
    bfba_pkg::cmd_t op_reg, op_next;
    logic           has_reg, has_next;
    logic [15:0]    bb_reg, bb_next;
    logic [17:0]    sz_reg, sz_next;
    logic [1:0]     att_reg, att_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [16:0]    dtop_reg, dtop_next;
    logic [15:0]    runs_reg, runs_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           zf_reg, zf_next;
    logic [IW-1:0]  zi_reg, zi_next;
    logic [15:0]    zb_reg, zb_next;
    logic [16:0]    zl_reg, zl_next;
    logic           hf_reg, hf_next;
    logic [IW-1:0]  hi_reg, hi_next;
    logic [15:0]    hb_reg, hb_next;
    logic [16:0]    hl_reg, hl_next;
    logic [15:0]    dptr_reg, dptr_next;
    logic [CW-1:0]  mi_reg, mi_next;
    logic           ui_reg, ui_next;
    logic [15:0]    bi_reg, bi_next;
    logic [16:0]    li_reg, li_next;
    logic           merged_reg, merged_next;
    logic [16:0]    top_reg, top_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           ov_reg, ov_next;
    logic [1:0]     stat_reg, stat_next;
    logic [15:0]    rb_reg, rb_next;
    logic [16:0]    rl_reg, rl_next;
    logic [15:0]    cs_reg, cs_next;
    logic [16:0]    cl_reg, cl_next;
    logic [15:0]    zs_reg, zs_next;
    logic [16:0]    zn_reg, zn_next;
    logic [16:0]    lf_reg, lf_next;
    logic [16:0]    tf_reg, tf_next;

    logic signed [SW-1:0] floor_s, dtop_s, sz_s, gap_s;
    logic                 idx_end, outside, fd_hit, ft_hit, room, new_fail;
    logic                 ext_fail, at_top, split, mg_cond, mg_abs;
    logic [17:0]          tp_sum;

    assign floor_s  = MEM_S - $signed(SW'(count_reg)) * HDR_S;
    assign dtop_s   = $signed(SW'(dtop_reg));
    assign sz_s     = $signed(SW'(sz_reg));
    assign gap_s    = floor_s - dtop_s;
    assign idx_end  = idx_reg >= count_reg;
    assign outside  = has_reg && (17'(bb_reg) > 17'(MEM_BYTES));
    assign fd_hit   = rd_q.used && (rd_q.base == bb_reg);
    assign ft_hit   = !rd_q.used && (18'(rd_q.len) >= sz_reg)
                      && (!hf_reg || (rd_q.len < hl_reg));
    assign room     = (count_reg < CW'(MAX_ENTRIES)) && (floor_s - HDR_S >= dtop_s);
    assign new_fail = (count_reg >= CW'(MAX_ENTRIES)) || (floor_s - HDR_S < dtop_s + sz_s);
    assign ext_fail = $signed(SW'(zb_reg)) + sz_s > floor_s;
    assign at_top   = (18'(zb_reg) + 18'(zl_reg)) == 18'(dtop_reg);
    assign split    = (19'(sz_reg) + 19'(SPLIT_SLACK)) < 19'(hl_reg);
    assign mg_cond  = (idx_reg != mi_reg) && (li_reg != '0) && (rd_q.len != '0)
                      && !rd_q.used && ((18'(bi_reg) + 18'(li_reg)) == 18'(rd_q.base));
    assign mg_abs   = !ui_reg || (19'(li_reg) >= 19'(rd_q.len) * 19'(bfba_pkg::MERGE_RATIO));
    assign tp_sum   = 18'(rd_q.base) + 18'(rd_q.len);
    assign mem_ra   = (state_reg == S_MI_RD) ? mi_reg[IW-1:0] : idx_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q <= mem[mem_ra];
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        has_next    = has_reg;
        bb_next     = bb_reg;
        sz_next     = sz_reg;
        att_next    = att_reg;
        count_next  = count_reg;
        dtop_next   = dtop_reg;
        runs_next   = runs_reg;
        idx_next    = idx_reg;
        zf_next     = zf_reg;
        zi_next     = zi_reg;
        zb_next     = zb_reg;
        zl_next     = zl_reg;
        hf_next     = hf_reg;
        hi_next     = hi_reg;
        hb_next     = hb_reg;
        hl_next     = hl_reg;
        dptr_next   = dptr_reg;
        mi_next     = mi_reg;
        ui_next     = ui_reg;
        bi_next     = bi_reg;
        li_next     = li_reg;
        merged_next = merged_reg;
        top_next    = top_reg;
        k_next      = k_reg;
        ov_next     = ov_reg;
        stat_next   = stat_reg;
        rb_next     = rb_reg;
        rl_next     = rl_reg;
        cs_next     = cs_reg;
        cl_next     = cl_reg;
        zs_next     = zs_reg;
        zn_next     = zn_reg;
        lf_next     = lf_reg;
        tf_next     = tf_reg;
        mem_we      = 1'b0;
        mem_wa      = idx_reg[IW-1:0];
        mem_wd      = rd_q;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = bfba_pkg::cmd_t'(command);
                    if (bfba_pkg::cmd_t'(command) == bfba_pkg::CMD_ALLOC && request_size == '0)
                    begin
                        op_next = bfba_pkg::CMD_FREE;
                    end
                    has_next   = has_block;
                    bb_next    = block_base;
                    sz_next    = (18'(request_size) + AMASK) & ~AMASK;
                    att_next   = 2'(bfba_pkg::RETRY_BUDGET + 1);
                    stat_next  = bfba_pkg::STAT_OK;
                    rb_next    = '0;
                    rl_next    = '0;
                    cs_next    = '0;
                    cl_next    = '0;
                    zs_next    = '0;
                    zn_next    = '0;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                unique case (op_reg)
                    bfba_pkg::CMD_MERGE:
                    begin
                        state_next = S_MG_START;
                    end
                    bfba_pkg::CMD_ALLOC:
                    begin
                        if (outside)
                        begin
                            stat_next  = bfba_pkg::STAT_OUTSIDE;
                            state_next = S_ST_INIT;
                        end
                        else
                        begin
                            state_next = S_TRY;
                        end
                    end
                    default:
                    begin
                        if (!has_reg)
                        begin
                            state_next = S_ST_INIT;
                        end
                        else if (outside)
                        begin
                            stat_next  = bfba_pkg::STAT_OUTSIDE;
                            state_next = S_ST_INIT;
                        end
                        else
                        begin
                            idx_next   = '0;
                            zf_next    = 1'b0;
                            state_next = S_FD_RD;
                        end
                    end
                endcase
            end
            S_TRY:
            begin
                zf_next = 1'b0;
                idx_next = '0;
                if (att_reg == 2'd0)
                begin
                    stat_next  = bfba_pkg::STAT_NO_MEM;
                    state_next = S_ST_INIT;
                end
                else if (has_reg)
                begin
                    state_next = S_FD_RD;
                end
                else
                begin
                    state_next = S_Z;
                end
            end
            S_FD_RD:
            begin
                state_next = idx_end ? S_FD_DONE : S_FD_CHK;
            end
            S_FD_CHK:
            begin
                if (fd_hit)
                begin
                    zf_next    = 1'b1;
                    zi_next    = idx_reg[IW-1:0];
                    zb_next    = rd_q.base;
                    zl_next    = rd_q.len;
                    state_next = S_FD_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FD_RD;
                end
            end
            S_FD_DONE:
            begin
                state_next = S_ST_INIT;
                if (!zf_reg)
                begin
                    stat_next = bfba_pkg::STAT_UNKNOWN;
                end
                else if (op_reg == bfba_pkg::CMD_FREE)
                begin
                    mem_we = 1'b1;
                    mem_wa = zi_reg;
                    mem_wd = '{used: 1'b0, base: zb_reg, len: zl_reg};
                end
                else if (op_reg == bfba_pkg::CMD_QUERY)
                begin
                    rl_next = zl_reg;
                end
                else
                begin
                    state_next = S_Z;
                end
            end
            S_Z:
            begin
                idx_next = '0;
                hf_next  = 1'b0;
                if (!zf_reg)
                begin
                    state_next = S_FT_RD;
                end
                else if (sz_reg == 18'(zl_reg))
                begin
                    rb_next    = zb_reg;
                    rl_next    = zl_reg;
                    state_next = S_ST_INIT;
                end
                else if (at_top)
                begin
                    if (ext_fail)
                    begin
                        att_next   = att_reg - 2'd1;
                        state_next = S_MG_START;
                    end
                    else
                    begin
                        if (sz_reg > 18'(zl_reg))
                        begin
                            zs_next = 16'(18'(zb_reg) + 18'(zl_reg));
                            zn_next = 17'(sz_reg - 18'(zl_reg));
                        end
                        mem_we     = 1'b1;
                        mem_wa     = zi_reg;
                        mem_wd     = '{used: 1'b1, base: zb_reg, len: 17'(sz_reg)};
                        dtop_next  = 17'(18'(zb_reg) + sz_reg);
                        rb_next    = zb_reg;
                        rl_next    = 17'(sz_reg);
                        state_next = S_ST_INIT;
                    end
                end
                else
                begin
                    state_next = S_FT_RD;
                end
            end
            S_FT_RD:
            begin
                state_next = idx_end ? S_FT_DONE : S_FT_CHK;
            end
            S_FT_CHK:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = S_FT_RD;
                if (ft_hit)
                begin
                    hf_next = 1'b1;
                    hi_next = idx_reg[IW-1:0];
                    hb_next = rd_q.base;
                    hl_next = rd_q.len;
                    if (18'(rd_q.len) == sz_reg)
                    begin
                        state_next = S_FT_DONE;
                    end
                end
            end
            S_FT_DONE:
            begin
                if (hf_reg)
                begin
                    if (split && att_reg > 2'd1 && !room)
                    begin
                        att_next   = att_reg - 2'd1;
                        state_next = S_MG_START;
                    end
                    else
                    begin
                        if (split && room)
                        begin
                            mem_we     = 1'b1;
                            mem_wa     = count_reg[IW-1:0];
                            mem_wd     = '{used: 1'b0,
                                           base: 16'(18'(hb_reg) + sz_reg),
                                           len:  17'(18'(hl_reg) - sz_reg)};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            sz_next = 18'(hl_reg);
                        end
                        dptr_next  = hb_reg;
                        state_next = S_GRANT;
                    end
                end
                else if (new_fail)
                begin
                    att_next   = att_reg - 2'd1;
                    state_next = S_MG_START;
                end
                else
                begin
                    dptr_next  = 16'(dtop_reg);
                    dtop_next  = 17'(18'(dtop_reg) + sz_reg);
                    hi_next    = count_reg[IW-1:0];
                    count_next = count_reg + 1'b1;
                    state_next = S_GRANT;
                end
            end
            S_GRANT:
            begin
                mem_we  = 1'b1;
                mem_wa  = hi_reg;
                mem_wd  = '{used: 1'b1, base: dptr_reg, len: 17'(sz_reg)};
                rb_next = dptr_reg;
                rl_next = 17'(sz_reg);
                if (zf_reg)
                begin
                    cs_next = zb_reg;
                    if (sz_reg > 18'(zl_reg))
                    begin
                        cl_next = zl_reg;
                        zs_next = 16'(18'(dptr_reg) + 18'(zl_reg));
                        zn_next = 17'(sz_reg - 18'(zl_reg));
                    end
                    else
                    begin
                        cl_next = 17'(sz_reg);
                    end
                    state_next = S_REL;
                end
                else
                begin
                    zs_next    = dptr_reg;
                    zn_next    = 17'(sz_reg);
                    state_next = S_ST_INIT;
                end
            end
            S_REL:
            begin
                mem_we     = 1'b1;
                mem_wa     = zi_reg;
                mem_wd     = '{used: 1'b0, base: zb_reg, len: zl_reg};
                state_next = S_ST_INIT;
            end
            S_MG_START:
            begin
                runs_next  = runs_reg + 16'd1;
                mi_next    = '0;
                state_next = S_MI_RD;
            end
            S_MI_RD:
            begin
                if (mi_reg >= count_reg)
                begin
                    idx_next   = '0;
                    top_next   = '0;
                    state_next = S_TP_RD;
                end
                else
                begin
                    state_next = S_MI_LD;
                end
            end
            S_MI_LD:
            begin
                ui_next     = rd_q.used;
                bi_next     = rd_q.base;
                li_next     = rd_q.len;
                merged_next = 1'b0;
                idx_next    = '0;
                state_next  = S_MJ_RD;
            end
            S_MJ_RD:
            begin
                if (idx_end)
                begin
                    mi_next    = merged_reg ? '0 : mi_reg + 1'b1;
                    state_next = S_MI_RD;
                end
                else
                begin
                    state_next = S_MJ_CHK;
                end
            end
            S_MJ_CHK:
            begin
                if (mg_cond && mg_abs)
                begin
                    li_next     = li_reg + rd_q.len;
                    mem_we      = 1'b1;
                    mem_wa      = idx_reg[IW-1:0];
                    mem_wd      = '{used: rd_q.used, base: rd_q.base, len: '0};
                    merged_next = 1'b1;
                    idx_next    = '0;
                    state_next  = S_MG_WR_I;
                end
                else if (mg_cond)
                begin
                    mi_next    = merged_reg ? '0 : mi_reg + 1'b1;
                    state_next = S_MI_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MJ_RD;
                end
            end
            S_MG_WR_I:
            begin
                mem_we     = 1'b1;
                mem_wa     = mi_reg[IW-1:0];
                mem_wd     = '{used: ui_reg, base: bi_reg, len: li_reg};
                state_next = S_MJ_RD;
            end
            S_TP_RD:
            begin
                if (idx_end)
                begin
                    idx_next   = '0;
                    k_next     = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_TP_CHK;
                end
            end
            S_TP_CHK:
            begin
                if (rd_q.used && tp_sum > 18'(top_reg))
                begin
                    top_next = 17'(tp_sum);
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_TP_RD;
            end
            S_CP_RD:
            begin
                state_next = idx_end ? S_MG_END : S_CP_CHK;
            end
            S_CP_CHK:
            begin
                if (rd_q.len != '0 && 17'(rd_q.base) < top_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = k_reg[IW-1:0];
                    mem_wd = rd_q;
                    k_next = k_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_CP_RD;
            end
            S_MG_END:
            begin
                count_next = k_reg;
                dtop_next  = top_reg;
                state_next = (op_reg == bfba_pkg::CMD_MERGE) ? S_ST_INIT : S_TRY;
            end
            S_ST_INIT:
            begin
                lf_next    = (gap_s < 0) ? '0 : 17'(gap_s);
                tf_next    = (gap_s < 0) ? '0 : 17'(gap_s);
                idx_next   = '0;
                state_next = S_ST_RD;
            end
            S_ST_RD:
            begin
                if (idx_end)
                begin
                    ov_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ST_CHK;
                end
            end
            S_ST_CHK:
            begin
                if (!rd_q.used)
                begin
                    if (rd_q.len > lf_reg)
                    begin
                        lf_next = rd_q.len;
                    end
                    tf_next = tf_reg + rd_q.len;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_ST_RD;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dtop_reg  <= '0;
            runs_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            has_reg    <= has_next;
            bb_reg     <= bb_next;
            sz_reg     <= sz_next;
            att_reg    <= att_next;
            count_reg  <= count_next;
            dtop_reg   <= dtop_next;
            runs_reg   <= runs_next;
            idx_reg    <= idx_next;
            zf_reg     <= zf_next;
            zi_reg     <= zi_next;
            zb_reg     <= zb_next;
            zl_reg     <= zl_next;
            hf_reg     <= hf_next;
            hi_reg     <= hi_next;
            hb_reg     <= hb_next;
            hl_reg     <= hl_next;
            dptr_reg   <= dptr_next;
            mi_reg     <= mi_next;
            ui_reg     <= ui_next;
            bi_reg     <= bi_next;
            li_reg     <= li_next;
            merged_reg <= merged_next;
            top_reg    <= top_next;
            k_reg      <= k_next;
            ov_reg     <= ov_next;
            stat_reg   <= stat_next;
            rb_reg     <= rb_next;
            rl_reg     <= rl_next;
            cs_reg     <= cs_next;
            cl_reg     <= cl_next;
            zs_reg     <= zs_next;
            zn_reg     <= zn_next;
            lf_reg     <= lf_next;
            tf_reg     <= tf_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign status       = stat_reg;
    assign result_base  = rb_reg;
    assign result_len   = rl_reg;
    assign copy_src     = cs_reg;
    assign copy_len     = cl_reg;
    assign zero_start   = zs_reg;
    assign zero_len     = zn_reg;
    assign largest_free = lf_reg;
    assign total_free   = tf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("header table count above capacity");

    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid && !in_stall))
        else $error("block not idle after result delivered");

    a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FD_CHK) |-> ($past(state_reg) == S_FD_RD))
        else $error("lookup compare without a table read");

endmodule

FILE: sim/tb_best_fit_block_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench of best_fit_block_allocator: directed and random commands.
// A scoreboard class predicts each result word; depends on bfba_pkg and the block.
module tb_best_fit_block_allocator;

    localparam int MEM      = 65536;
    localparam int ENTRIES  = 256;
    localparam int HDR      = 12;
    localparam int SLACK    = 4;
    localparam int ASHIFT   = 2;
    localparam int N_RANDOM = 1150;
    localparam int WATCHDOG = 10000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_base;
        logic [16:0] result_len;
        logic [15:0] copy_src;
        logic [16:0] copy_len;
        logic [15:0] zero_start;
        logic [16:0] zero_len;
        logic [16:0] largest_free;
        logic [16:0] total_free;
    } alloc_result_t;

    class allocator_scoreboard;
        bit          used[ENTRIES];
        int unsigned ebase[ENTRIES];
        int unsigned elen[ENTRIES];
        int unsigned count;
        int unsigned top;
        int unsigned runs;
        int unsigned last_base;
        alloc_result_t expected_q[$];
        int          mismatches;

        function void clear();
            count = 0;
            top = 0;
            runs = 0;
            last_base = 0;
            mismatches = 0;
        endfunction

        function longint hdr_floor();
            return longint'(MEM) - longint'(count) * HDR;
        endfunction

        function int lookup(int unsigned b);
            for (int unsigned i = 0; i < count; i++)
                if (used[i] && ebase[i] == b) return int'(i);
            return -1;
        endfunction

        function void merge_blocks();
            int unsigned i;
            int unsigned j;
            int unsigned k;
            int unsigned hi;
            bit merged;
            i = 0;
            hi = 0;
            runs = (runs + 1) & 16'hFFFF;
            while (i < count) begin
                merged = 0;
                j = 0;
                while (j < count) begin
                    if (j != i && elen[i] != 0 && elen[j] != 0 && !used[j] &&
                        ebase[i] + elen[i] == ebase[j]) begin
                        if (!used[i] ||
                            longint'(elen[i]) >= longint'(elen[j]) * bfba_pkg::MERGE_RATIO)
                        begin
                            elen[i] += elen[j];
                            elen[j] = 0;
                            merged = 1;
                            j = 0;
                            continue;
                        end
                        break;
                    end
                    j++;
                end
                i = merged ? 0 : i + 1;
            end
            for (i = 0; i < count; i++)
                if (used[i] && ebase[i] + elen[i] > hi) hi = ebase[i] + elen[i];
            top = hi;
            k = 0;
            for (i = 0; i < count; i++) begin
                if (elen[i] != 0 && ebase[i] < hi) begin
                    used[k] = used[i];
                    ebase[k] = ebase[i];
                    elen[k] = elen[i];
                    k++;
                end
            end
            count = k;
        endfunction

        function bfba_pkg::status_t release_block(bit has, int unsigned b);
            int idx;
            if (!has) return bfba_pkg::STAT_OK;
            if (b > MEM) return bfba_pkg::STAT_OUTSIDE;
            idx = lookup(b);
            if (idx < 0) return bfba_pkg::STAT_UNKNOWN;
            used[idx] = 0;
            return bfba_pkg::STAT_OK;
        endfunction

        function void grant(bit has, int unsigned b, int unsigned req, ref alloc_result_t r);
            int unsigned sz;
            int unsigned dptr;
            int unsigned zb;
            int unsigned zl;
            int tries;
            int z;
            int h;
            bit room;
            tries = bfba_pkg::RETRY_BUDGET;
            if (req == 0) begin
                r.status = release_block(has, b);
                return;
            end
            if (has && b > MEM) begin
                r.status = bfba_pkg::STAT_OUTSIDE;
                return;
            end
            sz = (req + (1 << ASHIFT) - 1) & ~((1 << ASHIFT) - 1);
            forever begin
                if (tries < 0) begin
                    r.status = bfba_pkg::STAT_NO_MEM;
                    return;
                end
                z = has ? lookup(b) : -1;
                if (has && z < 0) begin
                    r.status = bfba_pkg::STAT_UNKNOWN;
                    return;
                end
                if (z >= 0) begin
                    zb = ebase[z];
                    zl = elen[z];
                    if (sz == zl) begin
                        r.result_base = 16'(zb);
                        r.result_len = 17'(zl);
                        return;
                    end
                    if (zb + zl == top) begin
                        if (longint'(zb) + sz > hdr_floor()) begin
                            merge_blocks();
                            tries--;
                            continue;
                        end
                        if (sz > zl) begin
                            r.zero_start = 16'(zb + zl);
                            r.zero_len = 17'(sz - zl);
                        end
                        elen[z] = sz;
                        top = zb + sz;
                        r.result_base = 16'(zb);
                        r.result_len = 17'(sz);
                        return;
                    end
                end
                h = -1;
                for (int unsigned i = 0; i < count; i++) begin
                    if (!used[i] && elen[i] >= sz && (h < 0 || elen[i] < elen[h])) begin
                        h = int'(i);
                        if (elen[i] == sz) break;
                    end
                end
                if (h >= 0) begin
                    if (longint'(sz) + SLACK < elen[h]) begin
                        room = count < ENTRIES && hdr_floor() - HDR >= longint'(top);
                        if (tries != 0 && !room) begin
                            merge_blocks();
                            tries--;
                            continue;
                        end
                        if (room) begin
                            used[count] = 0;
                            ebase[count] = ebase[h] + sz;
                            elen[count] = elen[h] - sz;
                            elen[h] = sz;
                            count++;
                        end
                    end
                    sz = elen[h];
                    dptr = ebase[h];
                end
                else begin
                    if (count >= ENTRIES || hdr_floor() - HDR < longint'(top) + sz) begin
                        merge_blocks();
                        tries--;
                        continue;
                    end
                    dptr = top;
                    top += sz;
                    h = int'(count);
                    count++;
                end
                used[h] = 1;
                ebase[h] = dptr;
                elen[h] = sz;
                r.result_base = 16'(dptr);
                r.result_len = 17'(sz);
                if (z >= 0) begin
                    r.copy_src = 16'(ebase[z]);
                    if (sz > elen[z]) begin
                        r.copy_len = 17'(elen[z]);
                        r.zero_start = 16'(dptr + elen[z]);
                        r.zero_len = 17'(sz - elen[z]);
                    end
                    else begin
                        r.copy_len = 17'(sz);
                    end
                    used[z] = 0;
                end
                else begin
                    r.zero_start = 16'(dptr);
                    r.zero_len = 17'(sz);
                end
                return;
            end
        endfunction

        function void note_command(bfba_pkg::cmd_t cmd, bit has, int unsigned b,
                                   int unsigned req);
            alloc_result_t r;
            longint gap;
            longint big;
            longint sum;
            int f;
            r = '0;
            case (cmd)
                bfba_pkg::CMD_ALLOC: grant(has, b, req, r);
                bfba_pkg::CMD_FREE:  r.status = release_block(has, b);
                bfba_pkg::CMD_QUERY:
                    if (has) begin
                        if (b > MEM) r.status = bfba_pkg::STAT_OUTSIDE;
                        else begin
                            f = lookup(b);
                            if (f < 0) r.status = bfba_pkg::STAT_UNKNOWN;
                            else r.result_len = 17'(elen[f]);
                        end
                    end
                default:   merge_blocks();
            endcase
            gap = hdr_floor() - longint'(top);
            if (gap < 0) gap = 0;
            big = gap;
            sum = gap;
            for (int unsigned i = 0; i < count; i++) begin
                if (!used[i]) begin
                    if (elen[i] > big) big = elen[i];
                    sum += elen[i];
                end
            end
            r.largest_free = 17'(big);
            r.total_free = 17'(sum);
            if (r.status == bfba_pkg::STAT_OK && r.result_len != 0 &&
                cmd == bfba_pkg::CMD_ALLOC)
                last_base = r.result_base;
            expected_q.push_back(r);
        endfunction

        function void check_result(alloc_result_t a);
            alloc_result_t e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", a);
                return;
            end
            e = expected_q.pop_front();
            if (a !== e) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, a);
            end
        endfunction

        function int unsigned pick_live(output bit found);
            int unsigned live[$];
            for (int unsigned i = 0; i < count; i++)
                if (used[i]) live.push_back(i);
            found = live.size() != 0;
            if (!found) return 0;
            return live[$urandom_range(0, live.size() - 1)];
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic        has_block;
    logic [15:0] block_base;
    logic [16:0] request_size;
    logic        out_valid;
    logic        out_stall;
    alloc_result_t got;

    allocator_scoreboard sb;
    bit   quiet;
    bit   hold_req;
    bit   hold_done;
    int   hold_cycles;
    int   idle_cycles = 0;

    best_fit_block_allocator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .has_block    (has_block),
        .block_base   (block_base),
        .request_size (request_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (got.status),
        .result_base  (got.result_base),
        .result_len   (got.result_len),
        .copy_src     (got.copy_src),
        .copy_len     (got.copy_len),
        .zero_start   (got.zero_start),
        .zero_len     (got.zero_len),
        .largest_free (got.largest_free),
        .total_free   (got.total_free)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cycles <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_cycles <= 3000;
            hold_done <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(got);
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_word(bfba_pkg::cmd_t c, bit h, int unsigned b, int unsigned req);
        in_valid <= 1'b1;
        command <= c;
        has_block <= h;
        block_base <= 16'(b);
        request_size <= 17'(req);
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(c, h, b, req);
        if (!quiet && $urandom_range(0, 99) < 10)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    function automatic int unsigned rand_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 88) return $urandom_range(1, 600);
        if (r < 97) return $urandom_range(600, 8000);
        return $urandom_range(0, MEM);
    endfunction

    task automatic random_word();
        int unsigned r;
        int unsigned idx;
        bit found;
        r = $urandom_range(0, 99);
        idx = sb.pick_live(found);
        if (sb.count > 40 && r < 50) r = (r < 25) ? 55 : 80;
        if (r < 35 || (!found && r < 78))
            send_word(bfba_pkg::CMD_ALLOC, 1'b0, $urandom, rand_size());
        else if (r < 50)
            send_word(bfba_pkg::CMD_ALLOC, 1'b1, sb.ebase[idx],
                      ($urandom_range(0, 3) == 0) ? sb.elen[idx] : rand_size());
        else if (r < 65)
            send_word(r < 60 ? bfba_pkg::CMD_FREE : bfba_pkg::CMD_ALLOC, 1'b1,
                      sb.ebase[idx], 0);
        else if (r < 78)
            send_word(bfba_pkg::CMD_QUERY, 1'b1, sb.ebase[idx], $urandom_range(0, MEM));
        else if (r < 85)
            send_word(bfba_pkg::CMD_MERGE, $urandom_range(0, 1), $urandom,
                      $urandom_range(0, MEM));
        else if (r < 90)
            send_word(bfba_pkg::cmd_t'($urandom_range(0, 2)), 1'b1,
                      $urandom_range(0, 65535), rand_size());
        else
            send_word(bfba_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                      $urandom_range(0, 65535), $urandom_range(0, MEM));
    endtask

    initial
    begin
        int unsigned a;
        int unsigned b;
        sb = new();
        sb.clear();
        quiet = 0;
        hold_req = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = bfba_pkg::CMD_QUERY;
        has_block = 1'b0;
        block_base = '0;
        request_size = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(bfba_pkg::CMD_QUERY, 1'b0, 0, 0);
        send_word(bfba_pkg::CMD_FREE, 1'b0, 16'hFFFF, 0);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 0);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, MEM);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 1);
        a = sb.last_base;
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 100);
        b = sb.last_base;
        send_word(bfba_pkg::CMD_ALLOC, 1'b1, b, 100);
        send_word(bfba_pkg::CMD_ALLOC, 1'b1, b, 300);
        b = sb.last_base;
        send_word(bfba_pkg::CMD_ALLOC, 1'b1, b, 40);
        send_word(bfba_pkg::CMD_QUERY, 1'b1, b, 0);
        send_word(bfba_pkg::CMD_QUERY, 1'b1, 16'hFFFF, 0);
        send_word(bfba_pkg::CMD_FREE, 1'b1, 16'h1234, 0);
        send_word(bfba_pkg::CMD_ALLOC, 1'b1, 16'h5555, 8);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 400);
        send_word(bfba_pkg::CMD_FREE, 1'b1, b, 0);
        send_word(bfba_pkg::CMD_ALLOC, 1'b1, a, 16);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 40);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 60000);
        send_word(bfba_pkg::CMD_MERGE, 1'b1, 16'hAAAA, 17'h1FFFF & MEM);
        send_word(bfba_pkg::CMD_ALLOC, 1'b0, 0, 65000);
        send_word(bfba_pkg::CMD_ALLOC, 1'b1, sb.last_base, 0);
        send_word(bfba_pkg::CMD_MERGE, 1'b0, 0, 0);
        drain();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet = (n >= 300 && n < 500);
            if (n == 600) hold_req <= 1'b1;
            if (n == 800 || n == 1000) drain();
            random_word();
        end
        drain();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

FILE: best_fit_block_allocator.f
src/bfba_pkg.sv
src/best_fit_block_allocator.sv
sim/tb_best_fit_block_allocator.sv
